>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also covers the reset cycles.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/fdd_pkg.sv
// Shared types and constants of the frame delta decoder.
package fdd_pkg;

  localparam int MASK_GROUPS  = 5;
  localparam int GROUP_WORDS  = 16;
  localparam int WORD_W       = 16;
  localparam int POS_W        = 7;
  localparam int QUEUE_DEPTH  = 2;
  localparam int TERM_BIT     = 15;

  typedef enum logic [2:0] {
    PH_OFFSET = 3'b001,
    PH_MASKS  = 3'b010,
    PH_DATA   = 3'b100
  } phase_t;

  // One queued command: a screen write or a frame end.
  typedef struct packed {
    logic              frame_end;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] line_off;
    logic [WORD_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic avail;
  } q_stat_t;

endpackage

>>> rtl/frame_delta_decoder.sv
// An accepted data word or terminator is written to the queue, then loaded into the result register.
// Throughput: one stream word per cycle while the queue is not full; offset and mask words give no result.
// The front end walks the line's set mask bits with one lowest-bit pick per data word.
// A 2-item queue and the result register absorb short output stalls without stopping the input.
// Reset: synchronous, active low; clears parse phase, queue and result valid (no sweep).
module frame_delta_decoder #(
  parameter int MASK_GROUPS = fdd_pkg::MASK_GROUPS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fdd_pkg::WORD_W-1:0]  in_stream_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fdd_pkg::WORD_W-1:0]  out_write_offset,
  output logic [fdd_pkg::WORD_W-1:0]  out_write_data,
  output logic                        out_frame_end
);

  // Commands pass from the parser to the output stage through the queue.
  fdd_pkg::cmd_t    push_cmd;
  fdd_pkg::cmd_t    head_cmd;
  fdd_pkg::q_stat_t q_stat;
  logic             push;
  logic             pop;

  // Front end: offset, mask and data word parsing; stalls only on a full queue.
  fdd_front #(
    .MASK_GROUPS (MASK_GROUPS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_stream_word (in_stream_word),
    .q_stat         (q_stat),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  // Hold parsed writes and frame ends until the back end takes them.
  fdd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  // Back end: add line offset and twice the position, register the item.
  fdd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .head_cmd         (head_cmd),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_offset (out_write_offset),
    .out_write_data   (out_write_data),
    .out_frame_end    (out_frame_end)
  );

endmodule

>>> rtl/fdd_front.sv
// Front end: parses stream words and queues writes and frame ends.
module fdd_front #(
  parameter int MASK_GROUPS = fdd_pkg::MASK_GROUPS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fdd_pkg::WORD_W-1:0]  in_stream_word,
  input  fdd_pkg::q_stat_t            q_stat,
  output logic                        push,
  output fdd_pkg::cmd_t               push_cmd
);

  localparam int LINE_POS = MASK_GROUPS * fdd_pkg::GROUP_WORDS;
  localparam int CNT_W    = (MASK_GROUPS > 1) ? $clog2(MASK_GROUPS) : 1;
  localparam logic [CNT_W-1:0] LAST_MASK = CNT_W'(MASK_GROUPS - 1);

  fdd_pkg::phase_t phase_r, phase_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [fdd_pkg::WORD_W-1:0]  line_off_r, line_off_nxt;
  logic [fdd_pkg::WORD_W-1:0]  mask_r [MASK_GROUPS];
  logic [LINE_POS-1:0]         cur_r, cur_nxt;
  logic [LINE_POS-1:0]         rem_r, rem_nxt;
  logic [LINE_POS-1:0]         line_vec;
  logic [fdd_pkg::POS_W-1:0]   cur_pos;
  logic                        accept;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  // Position vector of the line: bit p set when line position p carries data.
  always_comb begin
    for (int g = 0; g < MASK_GROUPS; g++) begin
      for (int j = 0; j < fdd_pkg::GROUP_WORDS; j++) begin
        if (g == 0) begin
          line_vec[g*fdd_pkg::GROUP_WORDS + j] = in_stream_word[fdd_pkg::GROUP_WORDS-1-j];
        end else begin
          line_vec[g*fdd_pkg::GROUP_WORDS + j] =
            mask_r[MASK_GROUPS-1-g][fdd_pkg::GROUP_WORDS-1-j];
        end
      end
    end
  end

  // Encode the one-hot current position.
  always_comb begin
    cur_pos = '0;
    for (int i = 0; i < LINE_POS; i++) begin
      if (cur_r[i]) begin
        cur_pos = cur_pos | fdd_pkg::POS_W'(i);
      end
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    line_off_nxt = line_off_r;
    cur_nxt      = cur_r;
    rem_nxt      = rem_r;
    push         = 1'b0;
    push_cmd     = '0;
    if (accept) begin
      case (phase_r)
        fdd_pkg::PH_MASKS: begin
          if (cnt_r == LAST_MASK) begin
            cur_nxt   = line_vec & (~line_vec + LINE_POS'(1));
            rem_nxt   = line_vec & (line_vec - LINE_POS'(1));
            cnt_nxt   = '0;
            phase_nxt = (line_vec == '0) ? fdd_pkg::PH_OFFSET : fdd_pkg::PH_DATA;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        fdd_pkg::PH_DATA: begin
          push              = 1'b1;
          push_cmd.pos      = cur_pos;
          push_cmd.line_off = line_off_r;
          push_cmd.data     = in_stream_word;
          // advance to the next set position
          cur_nxt = rem_r & (~rem_r + LINE_POS'(1));
          rem_nxt = rem_r & (rem_r - LINE_POS'(1));
          if (rem_r == '0) begin
            phase_nxt = fdd_pkg::PH_OFFSET;
          end
        end
        default: begin
          cnt_nxt = '0;
          if (in_stream_word[fdd_pkg::TERM_BIT]) begin
            push               = 1'b1;
            push_cmd.frame_end = 1'b1;
            phase_nxt          = fdd_pkg::PH_OFFSET;
          end else begin
            line_off_nxt = in_stream_word;
            phase_nxt    = fdd_pkg::PH_MASKS;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fdd_pkg::PH_OFFSET;
      cnt_r   <= '0;
      cur_r   <= '0;
      rem_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      cur_r   <= cur_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    line_off_r <= line_off_nxt;
    if (accept && phase_r == fdd_pkg::PH_MASKS) begin
      mask_r[cnt_r] <= in_stream_word;
    end
  end

endmodule

>>> rtl/fdd_queue.sv
// Short command queue between the front end and the back end.
module fdd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fdd_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output fdd_pkg::cmd_t     head_cmd,
  output fdd_pkg::q_stat_t  q_stat
);

  localparam int PTR_W = (fdd_pkg::QUEUE_DEPTH > 1) ? $clog2(fdd_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(fdd_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(fdd_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(fdd_pkg::QUEUE_DEPTH);

  fdd_pkg::cmd_t    ent_r [fdd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign head_cmd     = ent_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == FULL_CNT);
  assign q_stat.avail = (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/fdd_back.sv
// Back end: forms screen write addresses and drives the result register.
module fdd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fdd_pkg::q_stat_t            q_stat,
  input  fdd_pkg::cmd_t               head_cmd,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fdd_pkg::WORD_W-1:0]  out_write_offset,
  output logic [fdd_pkg::WORD_W-1:0]  out_write_data,
  output logic                        out_frame_end
);

  logic                        valid_r, valid_nxt;
  logic [fdd_pkg::WORD_W-1:0]  offset_r, data_r;
  logic                        fend_r;
  logic [fdd_pkg::WORD_W-1:0]  offset_nxt;

  // Load whenever the result register is empty or being taken.
  assign pop = q_stat.avail && (!valid_r || !out_stall);

  // Byte offset wraps modulo 65536; a frame end carries zero offset and position.
  assign offset_nxt = head_cmd.line_off +
                      {{(fdd_pkg::WORD_W-fdd_pkg::POS_W-1){1'b0}}, head_cmd.pos, 1'b0};

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      offset_r <= offset_nxt;
      data_r   <= head_cmd.data;
      fend_r   <= head_cmd.frame_end;
    end
  end

  assign out_valid        = valid_r;
  assign out_write_offset = offset_r;
  assign out_write_data   = data_r;
  assign out_frame_end    = fend_r;

endmodule

>>> rtl/fdd_checker.sv
// Port-level checks of the frame delta decoder, bound to the top level.
`include "assert_macros.svh"

module fdd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [fdd_pkg::WORD_W-1:0]  out_write_offset,
  input logic [fdd_pkg::WORD_W-1:0]  out_write_data,
  input logic                        out_frame_end
);

  logic fend_ok;

  assign fend_ok = (out_write_offset == '0) && (out_write_data == '0);

  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid, "stalled item dropped")
  `ASSERT_CLK(a_frame_end_zero, out_valid && out_frame_end |-> fend_ok, "frame end not zeroed")
  `ASSERT_CLK_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result valid after reset")
  `ASSERT_CLK_ALWAYS(a_no_early_result, !rst_n ##1 rst_n |-> !out_valid, "early result")
  `ASSERT_CLK_ALWAYS(a_reset_ready, !rst_n |=> !in_stall, "input stalled after reset")

endmodule

bind frame_delta_decoder fdd_checker u_fdd_checker (.*);

>>> tb/sv/frame_delta_decoder_tb.sv
// Self-checking testbench of frame_delta_decoder: directed lines, backpressure and random streams.
`timescale 1ns / 100ps

module frame_delta_decoder_tb;

  localparam int MASK_GROUPS = fdd_pkg::MASK_GROUPS;
  localparam int GROUP_WORDS = fdd_pkg::GROUP_WORDS;
  localparam int WORD_W      = fdd_pkg::WORD_W;
  localparam int POS_W       = fdd_pkg::POS_W;
  localparam int TERM_BIT    = fdd_pkg::TERM_BIT;
  localparam int LINE_SLOTS  = MASK_GROUPS * GROUP_WORDS;
  localparam int HALF_CLK    = 4;
  localparam int HOLD_LONG   = 400;
  localparam int SETTLE      = 8;
  localparam int RAND_ITEMS  = 1000;

  // One screen write, or a frame end with zero offset and data.
  typedef struct packed {
    logic              frame_end;
    logic [WORD_W-1:0] offset;
    logic [WORD_W-1:0] data;
  } screen_write_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [WORD_W-1:0] in_stream_word;
  logic              out_valid;
  logic              out_stall;
  logic [WORD_W-1:0] out_write_offset;
  logic [WORD_W-1:0] out_write_data;
  logic              out_frame_end;

  // Decoder shadow: parse phase, masks in arrival order, line base and line position.
  fdd_pkg::phase_t   dec_phase = fdd_pkg::PH_OFFSET;
  logic [WORD_W-1:0] mask_hold [MASK_GROUPS];
  logic [WORD_W-1:0] line_base = '0;
  logic [POS_W-1:0]  line_pos  = '0;

  screen_write_t     pending_writes [$];
  int unsigned       mismatch_count = 0;
  int unsigned       words_sent     = 0;

  // Sender idling: bursts of random length with random gaps, when enabled.
  bit                gaps_on    = 1'b1;
  int unsigned       burst_left = 0;

  // Receiver hold-off request, picked up and counted down by the receiver process.
  int unsigned       hold_req = 0;

  frame_delta_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stream_word   (in_stream_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_offset (out_write_offset),
    .out_write_data   (out_write_data),
    .out_frame_end    (out_frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_CLK clk = ~clk;
  end

  // Abort a hung run.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Decoder shadow
  // ---------------------------------------------------------------------------

  // Test whether line position p has its mask bit set: group 0 uses the last mask.
  function automatic bit slot_dirty(int unsigned p);
    int unsigned grp;
    int unsigned bitn;
    grp  = p / GROUP_WORDS;
    bitn = (GROUP_WORDS - 1) - (p % GROUP_WORDS);
    if (grp >= MASK_GROUPS) return 1'b0;
    return mask_hold[MASK_GROUPS - 1 - grp][bitn];
  endfunction

  // Return the first dirty position at or after p, or LINE_SLOTS when the line is done.
  function automatic int unsigned next_dirty(int unsigned p);
    while (p < LINE_SLOTS && !slot_dirty(p)) p++;
    return p;
  endfunction

  // Advance the shadow by one accepted stream word and queue the write it causes.
  task automatic decode_word(input logic [WORD_W-1:0] w);
    int unsigned   p;
    screen_write_t wr;
    case (dec_phase)
      fdd_pkg::PH_MASKS: begin
        if (line_pos < MASK_GROUPS) mask_hold[line_pos] = w;
        line_pos = line_pos + 1'b1;
        if (line_pos >= MASK_GROUPS) begin
          p = next_dirty(0);
          // All masks zero: no data words follow, go back to the offset word.
          if (p >= LINE_SLOTS) begin
            dec_phase = fdd_pkg::PH_OFFSET;
            line_pos  = '0;
          end else begin
            dec_phase = fdd_pkg::PH_DATA;
            line_pos  = POS_W'(p);
          end
        end
      end
      fdd_pkg::PH_DATA: begin
        wr.frame_end = 1'b0;
        wr.offset    = WORD_W'(line_base + 2 * line_pos);
        wr.data      = w;
        pending_writes.push_back(wr);
        p = next_dirty(line_pos + 1);
        if (p >= LINE_SLOTS) begin
          dec_phase = fdd_pkg::PH_OFFSET;
          line_pos  = '0;
        end else begin
          line_pos = POS_W'(p);
        end
      end
      default: begin
        // Only an offset word is tested for the terminator bit.
        if (w[TERM_BIT]) begin
          wr = '{frame_end: 1'b1, offset: '0, data: '0};
          pending_writes.push_back(wr);
          dec_phase = fdd_pkg::PH_OFFSET;
          line_pos  = '0;
        end else begin
          line_base = w;
          line_pos  = '0;
          dec_phase = fdd_pkg::PH_MASKS;
        end
      end
    endcase
  endtask

  // Predict on each accepted word first, then check each accepted result against the
  // oldest pending write. Sampling at the rising edge sees the values from before it.
  always @(posedge clk) begin : check_results
    screen_write_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) decode_word(in_stream_word);
      if (out_valid && !out_stall) begin
        if (pending_writes.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result offset=%h data=%h frame_end=%b", $time,
                   out_write_offset, out_write_data, out_frame_end);
        end else begin
          want = pending_writes.pop_front();
          if (out_frame_end !== want.frame_end) begin
            mismatch_count++;
            $display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
                     out_frame_end);
          end
          if (out_write_offset !== want.offset) begin
            mismatch_count++;
            $display("%0t: write_offset expected %h actual %h", $time, want.offset,
                     out_write_offset);
          end
          if (out_write_data !== want.data) begin
            mismatch_count++;
            $display("%0t: write_data expected %h actual %h", $time, want.data,
                     out_write_data);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on a pattern that changes mode now and then, plus long hold-offs
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned tick;
    mode      = 0;
    mode_left = 100;
    hold_left = 0;
    tick      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        // Hold off the whole stretch so the block fills up.
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 99) < 30);
          2:       out_stall <= ((tick % 7) < 3);
          default: out_stall <= ($urandom_range(0, 99) < 60);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one word, holding it until accepted. Enter and leave at a falling edge.
  task automatic send_word(input logic [WORD_W-1:0] w);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      gap        = $urandom_range(0, 8);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    in_valid       <= 1'b1;
    in_stream_word <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    words_sent++;
  endtask

  // Send one changed line: offset, masks in arrival order, then random data words.
  task automatic send_line(input logic [WORD_W-1:0] offset,
                           input logic [WORD_W-1:0] masks [MASK_GROUPS]);
    int unsigned n_data;
    n_data = 0;
    send_word(offset);
    foreach (masks[i]) begin
      send_word(masks[i]);
      n_data += $countones(masks[i]);
    end
    repeat (n_data) send_word(WORD_W'($urandom));
  endtask

  // Pause the sender until every pending write has come, then let the pipe settle.
  task automatic drain_writes();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Draw a mask: mostly empty or sparse, now and then dense or full.
  function automatic logic [WORD_W-1:0] rand_mask();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return '0;
      4, 5:       return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
      6, 7:       return WORD_W'($urandom & $urandom & $urandom);
      8:          return WORD_W'($urandom);
      default:    return '1;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Terminator words at the offset phase, whatever the low bits hold.
  task automatic test_frame_end();
    send_word(16'h8000);
    send_word(16'hFFFF);
    send_word(16'h8001);
    drain_writes();
  endtask

  // All masks zero: no write, back to expecting an offset word.
  task automatic test_empty_line();
    logic [WORD_W-1:0] masks [MASK_GROUPS];
    foreach (masks[i]) masks[i] = '0;
    send_line(16'h0000, masks);
    drain_writes();
  endtask

  // Extreme offsets and positions; masks and data with bit 15 set are not terminators.
  task automatic test_line_extremes();
    logic [WORD_W-1:0] masks [MASK_GROUPS];
    foreach (masks[i]) masks[i] = '0;
    // First and last line position at the highest offset word.
    masks[0]           = 16'h0001;
    masks[MASK_GROUPS-1] = 16'h8000;
    send_word(16'h7FFF);
    foreach (masks[i]) send_word(masks[i]);
    send_word(16'hFFFF);
    send_word(16'h8000);
    // Both ends of a middle group, data words at zero and all ones below bit 15.
    foreach (masks[i]) masks[i] = '0;
    masks[2] = 16'h8001;
    send_word(16'h1234);
    foreach (masks[i]) send_word(masks[i]);
    send_word(16'h0000);
    send_word(16'h7FFF);
    drain_writes();
  endtask

  // Hold the receiver off for a long stretch while a full line streams in without gaps.
  task automatic test_receiver_holdoff();
    logic [WORD_W-1:0] masks [MASK_GROUPS];
    foreach (masks[i]) masks[i] = '1;
    gaps_on  = 1'b0;
    hold_req = HOLD_LONG;
    send_line(16'h0100, masks);
    send_word(16'h8000);
    gaps_on = 1'b1;
    drain_writes();
  endtask

  // Mostly well-formed lines with random content, some terminators, some raw noise.
  task automatic test_random_stream();
    logic [WORD_W-1:0] masks [MASK_GROUPS];
    logic [WORD_W-1:0] offset;
    int unsigned       stop_at;
    int unsigned       pick;
    stop_at = words_sent + RAND_ITEMS;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        send_word(WORD_W'($urandom) | 16'h8000);
      end else if (pick == 2) begin
        // Raw words, then finish whatever line they opened.
        repeat ($urandom_range(1, 6)) send_word(WORD_W'($urandom));
        while (dec_phase != fdd_pkg::PH_OFFSET) send_word(WORD_W'($urandom));
      end else begin
        offset = ($urandom_range(0, 9) == 0) ? WORD_W'($urandom_range(16'h7F00, 16'h7FFF))
                                             : WORD_W'($urandom_range(0, 16'h7FFF));
        foreach (masks[i]) masks[i] = ($urandom_range(0, 19) == 0) ? '0 : rand_mask();
        send_line(offset, masks);
      end
      // Now and then let the sender run flat out for a while.
      if ($urandom_range(0, 49) == 0) gaps_on = !gaps_on;
    end
    gaps_on = 1'b1;
    drain_writes();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (mask_hold[i]) mask_hold[i] = '0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_stream_word = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_frame_end();
    test_empty_line();
    test_line_extremes();
    test_receiver_holdoff();
    test_random_stream();

    repeat (SETTLE) @(negedge clk);
    if (mismatch_count == 0 && pending_writes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
